### sv/psd_pkg.sv
package psd_pkg;

  // Default coordinate width, signed Q.4
  localparam int COORD_W_DEF = 24;

  // Fixed field widths
  localparam int LEN_W      = 25;
  localparam int RATIO_W    = 32;
  localparam int DIST_W     = 25;
  localparam int FRAC_SHIFT = 16;

  // Dot magnitudes at or above 2^58 yield no orthogonal distance
  localparam int DOT_CAP_W = 58;

  // Chunk width of the split wide multipliers
  localparam int MUL_CHUNK = 29;

  localparam logic [DIST_W-1:0]  DIST_MAX      = '1;
  localparam logic [RATIO_W-1:0] RATIO_POS_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
  localparam logic [RATIO_W-1:0] RATIO_NEG_MAG = {1'b1, {(RATIO_W-1){1'b0}}};

endpackage

### sv/psd_isqrt.sv
// Pipelined integer square root, one root bit per stage.
// A new value may enter every enabled cycle.
module psd_isqrt #(
  parameter int IN_W = 66
) (
  input  logic                    clk,
  input  logic                    ce,
  input  logic [IN_W-1:0]         value,
  output logic [(IN_W+1)/2-1:0]   root
);

  localparam int RT_W  = (IN_W + 1) / 2;
  localparam int EV_W  = 2 * RT_W;
  localparam int REM_W = RT_W + 2;

  logic [EV_W-1:0]  v_q   [RT_W];
  logic [REM_W-1:0] rem_q [RT_W];
  logic [RT_W-1:0]  rt_q  [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    logic [EV_W-1:0]  v_in;
    logic [REM_W-1:0] rem_in;
    logic [RT_W-1:0]  rt_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in   = EV_W'(value);
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign rt_in  = rt_q[k-1];
    end

    // bring down two radicand bits, try root bit = 1
    assign rem_sh = {rem_in[REM_W-3:0], v_in[EV_W-1 -: 2]};
    assign trial  = {rt_in, 2'b01};

    always_ff @(posedge clk) begin
      if (ce) begin
        v_q[k] <= v_in << 2;
        if (rem_sh >= trial) begin
          rem_q[k] <= rem_sh - trial;
          rt_q[k]  <= {rt_in[RT_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem_sh;
          rt_q[k]  <= {rt_in[RT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt_q[RT_W-1];

endmodule

### sv/psd_mul.sv
// Wide unsigned multiplier split into chunk products.
// Registered in order: chunk products, row sums, final sum.
module psd_mul
  import psd_pkg::*;
#(
  parameter int A_W = 66,
  parameter int B_W = 50
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   p
);

  localparam int NA    = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB    = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AP_W  = NA * MUL_CHUNK;
  localparam int BP_W  = NB * MUL_CHUNK;
  localparam int PP_W  = 2 * MUL_CHUNK;
  localparam int ROW_W = MUL_CHUNK + BP_W;
  localparam int SUM_W = AP_W + BP_W;
  localparam int P_W   = A_W + B_W;

  logic [AP_W-1:0]  a_pad;
  logic [BP_W-1:0]  b_pad;
  logic [PP_W-1:0]  pp       [NA][NB];
  logic [ROW_W-1:0] row      [NA];
  logic [ROW_W-1:0] row_next [NA];
  logic [SUM_W-1:0] sum_next;

  assign a_pad = AP_W'(a);
  assign b_pad = BP_W'(b);

  // row and final sums
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (ROW_W'(pp[i][j]) << (j * MUL_CHUNK));
      end
    end
    sum_next = '0;
    for (int i = 0; i < NA; i++) begin
      sum_next = sum_next + (SUM_W'(row[i]) << (i * MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= PP_W'(a_pad[i*MUL_CHUNK +: MUL_CHUNK])
                    * PP_W'(b_pad[j*MUL_CHUNK +: MUL_CHUNK]);
        end
      end
      row <= row_next;
      p   <= P_W'(sum_next);
    end
  end

endmodule

### sv/point_segment_distances.sv
// Throughput: one word per cycle; the longest path is the orthogonal distance chain
// (split multiply, bit-serial-per-stage square root, then 25-stage divide by length).
// The whole pipeline advances together and holds while a result waits unread.
// Reset (rst, synchronous) clears the valid bits only; no other state is kept.
module point_segment_distances
  import psd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_W_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // prox_x, prox_y, prox_z, dist_x, dist_y, dist_z, query_x, query_y, query_z,
  // seg_length, zero pad
  input  logic [((9*COORD_WIDTH+LEN_W+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // proj_ratio, ortho_dist, end_dist, zero pad
  output logic [((RATIO_W+2*DIST_W+7)/8)*8-1:0] m_axis_tdata,
  // zero_length
  output logic [0:0] m_axis_tuser
);

  localparam int W      = COORD_WIDTH;
  localparam int OUT_TW = ((RATIO_W + 2*DIST_W + 7) / 8) * 8;
  localparam int DW     = W + 1;
  localparam int PW     = 2 * DW;
  localparam int DOT_W  = PW + 1;
  localparam int DMW    = 2 * W + 2;
  localparam int B2_W   = 2 * W + 2;
  localparam int L2_W   = 2 * LEN_W;
  localparam int NUM_W  = DMW + FRAC_SHIFT;
  localparam int RDR_W  = L2_W + 1;
  localparam int RW     = B2_W + L2_W;
  localparam int DSW    = (DMW < DOT_CAP_W) ? DMW : DOT_CAP_W;
  localparam int D2_W   = 2 * DSW;
  localparam int CMP_W  = (RW > D2_W) ? RW : D2_W;
  localparam int KR     = (RW + 1) / 2;
  localparam int KE     = (B2_W + 1) / 2;
  localparam int ODR_W  = LEN_W + 1;
  localparam int MUL_LAT = 3;
  localparam int LAT_O  = MUL_LAT + 1 + KR + 1 + DIST_W;
  localparam int LAT_R  = 1 + RATIO_W;
  localparam int LAT_E  = KE;
  localparam int DLY_R  = LAT_O - LAT_R;
  localparam int DLY_E  = LAT_O - LAT_E;
  localparam int NSTG   = LAT_O + 5;

  logic ce;
  logic vld [NSTG];

  // pipeline advances unless a result is held
  assign ce            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = ce;
  assign m_axis_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTG; k++) vld[k] <= 1'b0;
    end else if (ce) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) vld[k] <= vld[k-1];
    end
  end

  // input field unpack
  logic [W-1:0]     pc [3];
  logic [W-1:0]     dc [3];
  logic [W-1:0]     qc [3];
  logic [LEN_W-1:0] len_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pc[i] = s_axis_tdata[i*W +: W];
      dc[i] = s_axis_tdata[(3+i)*W +: W];
      qc[i] = s_axis_tdata[(6+i)*W +: W];
    end
    len_in = s_axis_tdata[9*W +: LEN_W];
  end

  // stage 1: difference vectors
  logic signed [DW-1:0] a1 [3];
  logic signed [DW-1:0] b1 [3];
  logic signed [DW-1:0] c1 [3];
  logic [LEN_W-1:0]     len1;

  // stage 2: products
  logic signed [PW-1:0] ab2 [3];
  logic signed [PW-1:0] bb2 [3];
  logic signed [PW-1:0] cc2 [3];
  logic [L2_W-1:0]      l2_2;

  // stage 3: sums
  logic signed [DOT_W-1:0] dot3;
  logic [B2_W-1:0]         b2_3;
  logic [B2_W-1:0]         c2_3;
  logic [L2_W-1:0]         l2_3;
  logic [LEN_W-1:0]        len2;
  logic [LEN_W-1:0]        len3;

  // stage 4: dot magnitude and sign
  logic [DMW-1:0]   dmag4;
  logic             dneg4;
  logic [B2_W-1:0]  b2_4;
  logic [B2_W-1:0]  c2_4;
  logic [L2_W-1:0]  l2_4;
  logic [LEN_W-1:0] len4;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        a1[i]  <= $signed({pc[i][W-1], pc[i]}) - $signed({dc[i][W-1], dc[i]});
        b1[i]  <= $signed({qc[i][W-1], qc[i]}) - $signed({dc[i][W-1], dc[i]});
        c1[i]  <= $signed({qc[i][W-1], qc[i]}) - $signed({pc[i][W-1], pc[i]});
        ab2[i] <= a1[i] * b1[i];
        bb2[i] <= b1[i] * b1[i];
        cc2[i] <= c1[i] * c1[i];
      end
      len1 <= len_in;
      l2_2 <= L2_W'(len1) * L2_W'(len1);
      len2 <= len1;

      dot3 <= DOT_W'(ab2[0]) + DOT_W'(ab2[1]) + DOT_W'(ab2[2]);
      b2_3 <= $unsigned(bb2[0]) + $unsigned(bb2[1]) + $unsigned(bb2[2]);
      c2_3 <= $unsigned(cc2[0]) + $unsigned(cc2[1]) + $unsigned(cc2[2]);
      l2_3 <= l2_2;
      len3 <= len2;

      dmag4 <= dot3[DOT_W-1] ? DMW'(-dot3) : DMW'(dot3);
      dneg4 <= dot3[DOT_W-1];
      b2_4  <= b2_3;
      c2_4  <= c2_3;
      l2_4  <= l2_3;
      len4  <= len3;
    end
  end

  // ---------------------------------------------------------------
  // Projection ratio: (dmag << 16) / L^2, one quotient bit per stage
  // ---------------------------------------------------------------
  logic [NUM_W-1:0]   num4;
  logic [RDR_W-1:0]   rr   [RATIO_W+1];
  logic [RATIO_W-1:0] rn   [RATIO_W+1];
  logic [L2_W-1:0]    rl   [RATIO_W+1];
  logic [RATIO_W-1:0] rq   [RATIO_W+1];
  logic               rbig [RATIO_W+1];
  logic               rneg [RATIO_W+1];

  assign num4 = {dmag4, {FRAC_SHIFT{1'b0}}};

  // quotient overflows 32 bits when num >= L^2 << 32
  always_ff @(posedge clk) begin
    if (ce) begin
      rr[0]   <= RDR_W'(num4 >> RATIO_W);
      rn[0]   <= num4[RATIO_W-1:0];
      rl[0]   <= l2_4;
      rq[0]   <= '0;
      rbig[0] <= (num4 >> RATIO_W) >= NUM_W'(l2_4);
      rneg[0] <= dneg4;
    end
  end

  for (genvar j = 0; j < RATIO_W; j++) begin : g_rdiv
    logic [RDR_W-1:0] rsh;
    logic             ge;

    assign rsh = {rr[j][RDR_W-2:0], rn[j][RATIO_W-1]};
    assign ge  = rsh >= {1'b0, rl[j]};

    always_ff @(posedge clk) begin
      if (ce) begin
        rr[j+1]   <= ge ? rsh - {1'b0, rl[j]} : rsh;
        rn[j+1]   <= rn[j] << 1;
        rl[j+1]   <= rl[j];
        rq[j+1]   <= {rq[j][RATIO_W-2:0], ge};
        rbig[j+1] <= rbig[j];
        rneg[j+1] <= rneg[j];
      end
    end
  end

  // zero for zero length, else saturate and apply sign
  logic [RATIO_W-1:0] ratio_fin;
  logic [RATIO_W-1:0] ratio_mag;

  always_comb begin
    ratio_mag = rq[RATIO_W];
    if (rl[RATIO_W] == '0) begin
      ratio_fin = '0;
    end else if (!rneg[RATIO_W]) begin
      ratio_fin = (rbig[RATIO_W] || rq[RATIO_W][RATIO_W-1]) ? RATIO_POS_MAX : rq[RATIO_W];
    end else begin
      if (rbig[RATIO_W] || rq[RATIO_W] > RATIO_NEG_MAG) ratio_mag = RATIO_NEG_MAG;
      ratio_fin = -ratio_mag;
    end
  end

  logic [RATIO_W-1:0] rdl [DLY_R];

  always_ff @(posedge clk) begin
    if (ce) begin
      rdl[0] <= ratio_fin;
      for (int k = 1; k < DLY_R; k++) rdl[k] <= rdl[k-1];
    end
  end

  // ---------------------------------------------------------------
  // Orthogonal distance: sqrt(|b|^2 L^2 - dot^2) / L
  // ---------------------------------------------------------------
  logic [RW-1:0]    bl_m;
  logic [D2_W-1:0]  d2_m;
  logic             obig4;
  logic             odb  [MUL_LAT];
  logic [LEN_W-1:0] odl  [MUL_LAT];

  assign obig4 = (dmag4 >> DSW) != '0;

  psd_mul #(
    .A_W (B2_W),
    .B_W (L2_W)
  ) u_bl_mul (
    .clk (clk),
    .ce  (ce),
    .a   (b2_4),
    .b   (l2_4),
    .p   (bl_m)
  );

  psd_mul #(
    .A_W (DSW),
    .B_W (DSW)
  ) u_d2_mul (
    .clk (clk),
    .ce  (ce),
    .a   (dmag4[DSW-1:0]),
    .b   (dmag4[DSW-1:0]),
    .p   (d2_m)
  );

  // radicand, zero when negative or the dot is out of range
  logic [RW-1:0]    rad;
  logic [LEN_W-1:0] lenr;
  logic             rad_pos;

  assign rad_pos = !odb[MUL_LAT-1] && (CMP_W'(bl_m) > CMP_W'(d2_m));

  always_ff @(posedge clk) begin
    if (ce) begin
      odb[0] <= obig4;
      odl[0] <= len4;
      for (int k = 1; k < MUL_LAT; k++) begin
        odb[k] <= odb[k-1];
        odl[k] <= odl[k-1];
      end
      rad  <= rad_pos ? RW'(CMP_W'(bl_m) - CMP_W'(d2_m)) : '0;
      lenr <= odl[MUL_LAT-1];
    end
  end

  logic [KR-1:0]    rroot;
  logic [LEN_W-1:0] lsq [KR];

  psd_isqrt #(
    .IN_W (RW)
  ) u_rad_sqrt (
    .clk   (clk),
    .ce    (ce),
    .value (rad),
    .root  (rroot)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      lsq[0] <= lenr;
      for (int k = 1; k < KR; k++) lsq[k] <= lsq[k-1];
    end
  end

  // root / L, one quotient bit per stage
  logic [ODR_W-1:0]  od   [DIST_W+1];
  logic [DIST_W-1:0] on   [DIST_W+1];
  logic [LEN_W-1:0]  ol   [DIST_W+1];
  logic [DIST_W-1:0] oq   [DIST_W+1];
  logic              obig [DIST_W+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      od[0]   <= ODR_W'(rroot >> DIST_W);
      on[0]   <= rroot[DIST_W-1:0];
      ol[0]   <= lsq[KR-1];
      oq[0]   <= '0;
      obig[0] <= (rroot >> DIST_W) >= KR'(lsq[KR-1]);
    end
  end

  for (genvar j = 0; j < DIST_W; j++) begin : g_odiv
    logic [ODR_W-1:0] osh;
    logic             ge;

    assign osh = {od[j][ODR_W-2:0], on[j][DIST_W-1]};
    assign ge  = osh >= {1'b0, ol[j]};

    always_ff @(posedge clk) begin
      if (ce) begin
        od[j+1]   <= ge ? osh - {1'b0, ol[j]} : osh;
        on[j+1]   <= on[j] << 1;
        ol[j+1]   <= ol[j];
        oq[j+1]   <= {oq[j][DIST_W-2:0], ge};
        obig[j+1] <= obig[j];
      end
    end
  end

  logic              zero_fin;
  logic [DIST_W-1:0] ortho_fin;

  assign zero_fin  = ol[DIST_W] == '0;
  assign ortho_fin = zero_fin ? '0 : (obig[DIST_W] ? DIST_MAX : oq[DIST_W]);

  // ---------------------------------------------------------------
  // Nearer endpoint distance
  // ---------------------------------------------------------------
  logic [KE-1:0]     e1;
  logic [KE-1:0]     e2;
  logic [KE-1:0]     emin;
  logic [DIST_W-1:0] end_fin;
  logic [DIST_W-1:0] edl [DLY_E];

  psd_isqrt #(
    .IN_W (B2_W)
  ) u_dist_sqrt (
    .clk   (clk),
    .ce    (ce),
    .value (b2_4),
    .root  (e1)
  );

  psd_isqrt #(
    .IN_W (B2_W)
  ) u_prox_sqrt (
    .clk   (clk),
    .ce    (ce),
    .value (c2_4),
    .root  (e2)
  );

  assign emin    = (e1 < e2) ? e1 : e2;
  assign end_fin = (emin > DIST_MAX) ? DIST_MAX : DIST_W'(emin);

  always_ff @(posedge clk) begin
    if (ce) begin
      edl[0] <= end_fin;
      for (int k = 1; k < DLY_E; k++) edl[k] <= edl[k-1];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (ce) begin
      m_axis_tdata <= OUT_TW'({edl[DLY_E-1], ortho_fin, rdl[DLY_R-1]});
      m_axis_tuser <= zero_fin;
    end
  end

endmodule

### tb/point_segment_distances_tb.sv
module point_segment_distances_tb;
  import psd_pkg::*;

  localparam int CW    = COORD_W_DEF;
  localparam int IN_W  = ((9*CW+LEN_W+7)/8)*8;
  localparam int OUT_W = ((RATIO_W+2*DIST_W+7)/8)*8;
  localparam int LAT   = CW + 61;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [LEN_W-1:0] seg_length;
    logic [CW-1:0] qz, qy, qx, dz, dy, dx, pz, py, px;
  } seg_query_t;

  typedef struct {
    logic [RATIO_W-1:0] proj_ratio;
    logic [DIST_W-1:0]  ortho_dist;
    logic [DIST_W-1:0]  end_dist;
    logic               zero_length;
  } distances_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  point_segment_distances u_dut (.*);

  always #2 clk = ~clk;

  seg_query_t pending_q[$];
  distances_t expected_q[$];
  int n_errors = 0;
  int n_results = 0;
  int n_zero_len = 0;
  int n_sat = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cycles = 0;
  int idle_cycles = 0;

  // floor square root of an unsigned 128-bit value
  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(logic [127:0] v);
    return (v > DIST_MAX) ? DIST_MAX : v[DIST_W-1:0];
  endfunction

  // expected distances for one segment/query word
  function automatic distances_t segment_distances(seg_query_t w);
    logic signed [127:0] p[3], d[3], q[3], a[3], b[3], c[3];
    logic signed [127:0] dot;
    logic [127:0] dmag, b2, c2, l2, quo, bl, e1, e2;
    logic [63:0] len;
    distances_t r;
    p[0] = 128'($signed(w.px)); p[1] = 128'($signed(w.py)); p[2] = 128'($signed(w.pz));
    d[0] = 128'($signed(w.dx)); d[1] = 128'($signed(w.dy)); d[2] = 128'($signed(w.dz));
    q[0] = 128'($signed(w.qx)); q[1] = 128'($signed(w.qy)); q[2] = 128'($signed(w.qz));
    dot = 0; b2 = 0; c2 = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = p[i] - d[i];
      b[i] = q[i] - d[i];
      c[i] = q[i] - p[i];
      dot += a[i] * b[i];
      b2 += b[i] * b[i];
      c2 += c[i] * c[i];
    end
    dmag = (dot < 0) ? -dot : dot;
    len = 64'(w.seg_length);
    r.proj_ratio = '0;
    r.ortho_dist = '0;
    if (len != 0) begin
      l2 = len * len;
      quo = (dmag << FRAC_SHIFT) / l2;
      if (dot >= 0) r.proj_ratio = (quo > RATIO_POS_MAX) ? RATIO_POS_MAX : quo[31:0];
      else r.proj_ratio = (quo > RATIO_NEG_MAG) ? RATIO_NEG_MAG : -quo[31:0];
      bl = b2 * l2;
      if (dmag < (128'd1 << DOT_CAP_W) && bl > dmag * dmag)
        r.ortho_dist = sat_dist(128'(isqrt128(bl - dmag * dmag) / len));
    end
    e1 = 128'(isqrt128(b2));
    e2 = 128'(isqrt128(c2));
    r.end_dist = sat_dist((e1 < e2) ? e1 : e2);
    r.zero_length = (len == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch on result %0d: %s got %h expected %h", n_results, what, got, exp);
    n_errors++;
  endtask

  task automatic enqueue_query(seg_query_t w);
    pending_q = {pending_q, w};
  endtask

  // driver: offers queued words, idling at random
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) void'(pending_q.pop_front());
      if ((!s_axis_tvalid || s_axis_tready) && pending_q.size() > 0) begin
        if ($urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_W'(pending_q[0]);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end else if (s_axis_tvalid && s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // predictor on accepted input words
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_q = {expected_q,
                    segment_distances(seg_query_t'(s_axis_tdata[9*CW+LEN_W-1:0]))};
  end

  // receiver ready: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 3 * LAT;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    distances_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
      end else begin
        e = expected_q.pop_front();
        if (e.zero_length) n_zero_len++;
        if (e.ortho_dist == DIST_MAX || e.end_dist == DIST_MAX ||
            e.proj_ratio == RATIO_POS_MAX || e.proj_ratio == RATIO_NEG_MAG) n_sat++;
        if (m_axis_tdata[RATIO_W-1:0] !== e.proj_ratio)
          report_mismatch("proj_ratio", 64'(m_axis_tdata[RATIO_W-1:0]), 64'(e.proj_ratio));
        if (m_axis_tdata[RATIO_W+DIST_W-1:RATIO_W] !== e.ortho_dist)
          report_mismatch("ortho_dist", 64'(m_axis_tdata[RATIO_W+DIST_W-1:RATIO_W]),
                          64'(e.ortho_dist));
        if (m_axis_tdata[RATIO_W+2*DIST_W-1:RATIO_W+DIST_W] !== e.end_dist)
          report_mismatch("end_dist", 64'(m_axis_tdata[RATIO_W+2*DIST_W-1:RATIO_W+DIST_W]),
                          64'(e.end_dist));
        if (m_axis_tuser[0] !== e.zero_length)
          report_mismatch("zero_length", 64'(m_axis_tuser[0]), 64'(e.zero_length));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress");
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [CW-1:0] rand_coord(int mode);
    logic [CW-1:0] v;
    v = CW'($urandom);
    case (mode)
      0: v = CW'($signed(12'($urandom)));
      1: v = CW'($signed(18'($urandom)));
      default: ;
    endcase
    return v;
  endfunction

  function automatic seg_query_t rand_query();
    seg_query_t w;
    int mode;
    logic [CW-1:0] base;
    mode = $urandom_range(3);
    base = rand_coord(mode == 3 ? 2 : 0);
    w.px = rand_coord(mode); w.py = rand_coord(mode); w.pz = rand_coord(mode);
    w.dx = rand_coord(mode); w.dy = rand_coord(mode); w.dz = rand_coord(mode);
    w.qx = rand_coord(mode); w.qy = rand_coord(mode); w.qz = rand_coord(mode);
    // sometimes points sit together
    if ($urandom_range(15) == 0) begin
      w.qx = w.dx; w.qy = w.dy; w.qz = w.dz;
    end
    if ($urandom_range(15) == 0) begin
      w.px = w.dx + base; w.py = w.dy; w.pz = w.dz;
    end
    case ($urandom_range(7))
      0: w.seg_length = '0;
      1: w.seg_length = LEN_W'($urandom_range(1, 16));
      2: w.seg_length = '1;
      3: w.seg_length = LEN_W'($urandom);
      default: w.seg_length = LEN_W'($urandom_range(1, 1 << (mode == 0 ? 13 : 20)));
    endcase
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) @(posedge clk);
  endtask

  seg_query_t w;
  logic [CW-1:0] cmax, cmin;

  initial begin
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero length, extremes, collinear, stray-free saturation
    w = '0; enqueue_query(w);
    w = '0; w.seg_length = '1; enqueue_query(w);
    w = '0; w.px = 16; w.qx = 8; w.seg_length = 16; enqueue_query(w);
    w = '0; w.px = 16; w.qx = 8; w.qy = 32; w.seg_length = 16; enqueue_query(w);
    w = '0; w.px = 16; w.qx = -8; w.seg_length = 16; enqueue_query(w);
    w = '0; w.px = 16; w.qx = 8; w.seg_length = 0; enqueue_query(w);
    w = '0; w.px = 16; w.qx = 16; w.seg_length = 4; enqueue_query(w);
    w = '0; w.px = cmax; w.dx = cmin; w.qx = cmax; w.seg_length = 1; enqueue_query(w);
    w = '0; w.px = cmin; w.dx = cmax; w.qx = cmax; w.seg_length = 1; enqueue_query(w);
    w = '{seg_length: '1, qz: cmax, qy: cmax, qx: cmax, dz: cmin, dy: cmin, dx: cmin,
          pz: cmin, py: cmin, px: cmin};
    enqueue_query(w);
    w.seg_length = 1; enqueue_query(w);
    w = '{seg_length: 1, qz: cmin, qy: cmax, qx: cmin, dz: cmax, dy: cmin, dx: cmax,
          pz: cmin, py: cmax, px: cmin};
    enqueue_query(w);
    w = '{seg_length: '1, qz: '1, qy: '1, qx: '1, dz: '1, dy: '1, dx: '1,
          pz: '1, py: '1, px: '1};
    enqueue_query(w);
    w = '0; w.qy = cmax; w.qz = cmax; w.seg_length = 1; enqueue_query(w);
    w = '0; w.px = 160; w.py = 160; w.qy = 3; w.seg_length = 37; enqueue_query(w);
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 17 : 0;
      recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 17 : 0;
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < 460; i++) begin
        enqueue_query(rand_query());
        if (ph == 1 && i == 230) wait_drained();
      end
      wait_drained();
    end
    repeat (LAT + 10) @(posedge clk);

    $display("ran %0d result words, %0d zero-length, %0d saturating, over four idle mixes",
             n_results, n_zero_len, n_sat);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
